### rtl/arace_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package arace_pkg;

    localparam int ADDR_W    = 64;
    localparam int SEQ_W     = 31;
    localparam int WRITER_W  = 2;
    localparam int CMD_W     = 3;
    localparam int CPU_W     = 2;
    localparam int ORDER_W   = 3;
    localparam int CPUS_DEF    = 4;
    localparam int ENTRIES_DEF = 1024;

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STORE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BOOT    = 3'd4;

    localparam logic [ORDER_W-1:0] ORD_ACQUIRE = 3'd2;
    localparam logic [ORDER_W-1:0] ORD_RELEASE = 3'd3;
    localparam logic [ORDER_W-1:0] ORD_ACQ_REL = 3'd4;
    localparam logic [ORDER_W-1:0] ORD_SEQ_CST = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OWN,
        ST_LAUNCH,
        ST_WAIT
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic                live;
        logic                found;
        logic [WRITER_W-1:0] writer;
        logic [SEQ_W-1:0]    seq;
    } tok_t;

    // broadcast entry update
    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [WRITER_W-1:0] writer;
        logic [SEQ_W-1:0]    seq;
    } entry_wr_t;

endpackage
`default_nettype wire

### rtl/access_race_detector_table.sv
// Boot passes from accept through the own state to a registered result; ignored
// items and order faults register their result on accept. Reads and acquire
// loads pass launch and wait, writes and release stores pass own, launch and
// wait; in wait the search token walks the row of table cells. One item at a time;
// next beat taken the cycle after the result goes. Reset (aresetn, synchronous,
// active low) zeroes all clock vectors, every table entry and the reclaim pointer.
`timescale 1ns / 1ps
`default_nettype none
module access_race_detector_table #(
    parameter int CPUS    = arace_pkg::CPUS_DEF,
    parameter int ENTRIES = arace_pkg::ENTRIES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [arace_pkg::CMD_W-1:0]    s_command,
    input  wire logic [arace_pkg::CPU_W-1:0]    s_cpu,
    input  wire logic [arace_pkg::ADDR_W-1:0]   s_addr,
    input  wire logic [arace_pkg::ORDER_W-1:0]  s_order,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_race,
    output logic                                m_order_fault
);
    import arace_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;

    state_t state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [CPU_W-1:0]    cpu_reg, cpu_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SEQ_W-1:0]    stamp_reg, stamp_next;
    logic [IW-1:0]       ptr_reg, ptr_next;
    logic [SEQ_W-1:0]    cv_reg [CPUS][CPUS];
    logic [SEQ_W-1:0]    cv_next [CPUS][CPUS];
    logic                out_valid_reg, out_valid_next;
    logic                race_reg, race_next;
    logic                fault_reg, fault_next;

    tok_t                tok_w [ENTRIES+1];
    logic [IW-1:0]       idx_w [ENTRIES+1];
    entry_wr_t           wr;
    logic [IW-1:0]       wr_idx;

    logic                accept, ignore, acq_ok, rel_ok;
    logic [CW-1:0]       cpu_ix, w_ix;
    logic [WRITER_W-1:0] ew, wmod;
    logic [SEQ_W-1:0]    es, own;
    logic                hit, stamping;

    assign accept = s_valid && s_ready;
    assign ignore = (32'(s_cpu) >= CPUS) || (s_command > CMD_BOOT);
    assign acq_ok = s_order inside {ORD_ACQUIRE, ORD_ACQ_REL, ORD_SEQ_CST};
    assign rel_ok = s_order inside {ORD_RELEASE, ORD_ACQ_REL, ORD_SEQ_CST};

    assign cpu_ix   = CW'(cpu_reg);
    assign own      = cv_reg[cpu_ix][cpu_ix];
    assign hit      = tok_w[ENTRIES].found;
    assign ew       = hit ? tok_w[ENTRIES].writer : '0;
    assign es       = hit ? tok_w[ENTRIES].seq : '0;
    assign wmod     = (32'(ew) >= CPUS) ? WRITER_W'(32'(ew) - CPUS) : ew;
    assign w_ix     = CW'(wmod);
    assign stamping = (cmd_reg == CMD_WRITE) || (cmd_reg == CMD_STORE);

    assign tok_w[0] = '{live: (state_reg == ST_LAUNCH), found: 1'b0,
                        writer: '0, seq: '0};
    assign idx_w[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        arace_cell #(
            .IW     (IW),
            .MY_IDX (IW'(i))
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .query_addr (addr_reg),
            .wr         (wr),
            .wr_idx     (wr_idx),
            .tok_in     (tok_w[i]),
            .idx_in     (idx_w[i]),
            .tok_out    (tok_w[i+1]),
            .idx_out    (idx_w[i+1])
        );
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cpu_next       = cpu_reg;
        addr_next      = addr_reg;
        stamp_next     = stamp_reg;
        ptr_next       = ptr_reg;
        cv_next        = cv_reg;
        out_valid_next = out_valid_reg;
        race_next      = race_reg;
        fault_next     = fault_reg;
        wr             = '0;
        wr_idx         = ptr_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next  = s_command;
                    cpu_next  = s_cpu;
                    addr_next = s_addr;
                    if (ignore) begin
                        out_valid_next = 1'b1;
                        race_next      = 1'b0;
                        fault_next     = 1'b0;
                    end else if ((s_command == CMD_LOAD && !acq_ok) ||
                                 (s_command == CMD_STORE && !rel_ok)) begin
                        out_valid_next = 1'b1;
                        race_next      = 1'b0;
                        fault_next     = 1'b1;
                    end else if (s_command == CMD_READ || s_command == CMD_LOAD) begin
                        state_next = ST_LAUNCH;
                    end else begin
                        state_next = ST_OWN;
                    end
                end
            end
            ST_OWN: begin
                // own count before the bump is the stamp; the bump saturates
                stamp_next = own;
                if (own != SEQ_MAX) begin
                    cv_next[cpu_ix][cpu_ix] = own + 1'b1;
                end
                if (cmd_reg == CMD_BOOT) begin
                    out_valid_next = 1'b1;
                    race_next      = 1'b0;
                    fault_next     = 1'b0;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (tok_w[ENTRIES].live) begin
                    wr.en   = 1'b1;
                    wr.addr = addr_reg;
                    if (hit) begin
                        wr_idx = idx_w[ENTRIES];
                    end else begin
                        ptr_next = (32'(ptr_reg) == ENTRIES - 1) ? '0 : ptr_reg + 1'b1;
                    end
                    if (stamping) begin
                        wr.writer = cpu_reg;
                        wr.seq    = stamp_reg;
                    end else begin
                        wr.writer = ew;
                        wr.seq    = es;
                    end
                    race_next  = (cmd_reg == CMD_READ) && (cv_reg[cpu_ix][w_ix] < es);
                    fault_next = 1'b0;
                    if (cmd_reg == CMD_LOAD && es != '0) begin
                        cv_next[cpu_ix][w_ix] = es;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CPUS; c++) begin
                for (int k = 0; k < CPUS; k++) begin
                    cv_reg[c][k] <= '0;
                end
            end
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            cv_reg        <= cv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        cpu_reg   <= cpu_next;
        addr_reg  <= addr_next;
        stamp_reg <= stamp_next;
        race_reg  <= race_next;
        fault_reg <= fault_next;
    end

    assign s_ready       = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid       = out_valid_reg;
    assign m_race        = race_reg;
    assign m_order_fault = fault_reg;

    a_token_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_w[ENTRIES].live |-> state_reg == ST_WAIT)
        else $error("search token left the chain outside the wait state");

    a_race_fault_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(race_reg && fault_reg))
        else $error("race and order fault raised on one beat");

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < ENTRIES)
        else $error("reclaim pointer beyond the table");

    a_launch_starts_search: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LAUNCH |=> state_reg == ST_WAIT)
        else $error("launch not followed by search");

endmodule
`default_nettype wire

### rtl/arace_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module arace_cell #(
    parameter int IW = 10,
    parameter logic [IW-1:0] MY_IDX = '0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [arace_pkg::ADDR_W-1:0] query_addr,
    input  wire arace_pkg::entry_wr_t         wr,
    input  wire logic [IW-1:0]               wr_idx,
    input  wire arace_pkg::tok_t              tok_in,
    input  wire logic [IW-1:0]               idx_in,
    output arace_pkg::tok_t                   tok_out,
    output logic [IW-1:0]                    idx_out
);
    import arace_pkg::*;

    logic [ADDR_W-1:0]   addr_reg;
    logic [WRITER_W-1:0] writer_reg;
    logic [SEQ_W-1:0]    seq_reg;
    tok_t                tok_reg, tok_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                hit;

    assign hit = tok_in.live && !tok_in.found && (addr_reg == query_addr);

    always_comb begin
        tok_next = tok_in;
        idx_next = idx_in;
        if (hit) begin
            tok_next.found  = 1'b1;
            tok_next.writer = writer_reg;
            tok_next.seq    = seq_reg;
            idx_next        = MY_IDX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            writer_reg <= '0;
            seq_reg    <= '0;
            tok_reg    <= '0;
            idx_reg    <= '0;
        end else begin
            tok_reg <= tok_next;
            idx_reg <= idx_next;
            if (wr.en && wr_idx == MY_IDX) begin
                addr_reg   <= wr.addr;
                writer_reg <= wr.writer;
                seq_reg    <= wr.seq;
            end
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule
`default_nettype wire
